/* rtl/ivkf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ivkf_pkg
// Shared types, codes and fixed-point helpers of the IMU velocity filter.
// ----------------------------------------------------------------------------
package ivkf_pkg;

  // Wide signed working type for products, sums and rounding.
  typedef logic signed [69:0] wide_t;

  // Datapath operations; the controller state doubles as the operation code.
  typedef enum logic [4:0] {
    OP_IDLE, OP_LOAD, OP_QMUL, OP_QSAVE, OP_NORM, OP_DSTART, OP_DWAIT,
    OP_DSAVE, OP_RMUL, OP_RACC, OP_WSAVE, OP_KSTART, OP_KWAIT, OP_KSAVE,
    OP_TMUL, OP_ADT, OP_VPRED, OP_DIFF, OP_KMUL, OP_CORR, OP_VSAVE,
    OP_PMUL, OP_PSAVE, OP_OUT
  } op_e;

  typedef enum logic [1:0] {
    CFG_TIME_STEP, CFG_PROC_NOISE, CFG_MEAS_NOISE, CFG_GRAVITY
  } cfg_idx_e;

  typedef struct packed {
    op_e        op;
    logic [3:0] idx;
    logic [1:0] col;
    logic [1:0] row;
  } cmd_t;

  typedef struct packed {
    logic n_zero;
    logic den_zero;
    logic div_idle;
    logic out_blocked;
  } sts_t;

  localparam logic [15:0] TimeStepReset = 16'd66;
  localparam logic [30:0] ProcNoiseReset = 31'd3277;
  localparam logic [30:0] MeasNoiseReset = 31'd6554;
  localparam logic [30:0] GravityReset = 31'd642908;
  localparam logic [31:0] CovReset = 32'd65536;
  localparam logic signed [31:0] OneQ30 = 32'sd1073741824;
  localparam logic [16:0] OneQ16 = 17'h10000;
  localparam logic [3:0] LastProd = 4'd9;
  localparam logic [3:0] LastRot = 4'd8;

  localparam wide_t SatMax = 70'sd2147483647;
  localparam wide_t SatMin = -70'sd2147483648;

  // Round half away from zero, then divide by 2^s.
  function automatic wide_t rnd_shift(input wide_t x, input int s);
    logic [69:0] mag;
    logic [69:0] half;
    mag  = x[69] ? 70'(-x) : 70'(x);
    half = 70'(1) << (s - 1);
    mag  = (mag + half) >> s;
    return x[69] ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic logic signed [31:0] sat32(input wide_t x);
    if (x > SatMax) begin
      return 32'sh7FFFFFFF;
    end else if (x < SatMin) begin
      return 32'sh80000000;
    end
    return x[31:0];
  endfunction

endpackage
`default_nettype wire

/* rtl/imu_velocity_kalman_filter.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imu_velocity_kalman_filter
// Rotates IMU samples to the world frame and runs a scalar Kalman velocity step.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i/in_stall_o carry one item (quaternion plus body
// acceleration). An item is taken when valid is high and stall is low.
// Output channel: out_valid_o/out_stall_i carry the filtered world velocity,
// one result item per input item.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 time step, 1 process noise, 2 measurement noise, 3 gravity); write only
// while no item is in flight.
// Timing: one item at a time. The pace is set by the shared serial divider,
// which runs once for each of the nine rotation entries and once for the
// gain. A zero quaternion skips the rotation divisions, and a zero p + r
// skips the gain division.
// Reset clears velocity to zero, covariance to 1.0 and registers to defaults.
// A stalled result waits in the output register while the next item is
// processed; the block only holds before writing a new result over it.
// ----------------------------------------------------------------------------
module imu_velocity_kalman_filter (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [30:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] quat_w_i,
  input  logic signed [15:0] quat_x_i,
  input  logic signed [15:0] quat_y_i,
  input  logic signed [15:0] quat_z_i,
  input  logic signed [31:0] body_accel_x_i,
  input  logic signed [31:0] body_accel_y_i,
  input  logic signed [31:0] body_accel_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] vel_x_o,
  output logic signed [31:0] vel_y_o,
  output logic signed [31:0] vel_z_o
);

  ivkf_pkg::cmd_t cmd;
  ivkf_pkg::sts_t sts;

  ivkf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  ivkf_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .quat_w_i       (quat_w_i),
    .quat_x_i       (quat_x_i),
    .quat_y_i       (quat_y_i),
    .quat_z_i       (quat_z_i),
    .body_accel_x_i (body_accel_x_i),
    .body_accel_y_i (body_accel_y_i),
    .body_accel_z_i (body_accel_z_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .vel_x_o        (vel_x_o),
    .vel_y_o        (vel_y_o),
    .vel_z_o        (vel_z_o)
  );

  // An accepted item keeps the input closed on the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input open right after accepting an item");

  // A new result only appears after an item has been worked on.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without an item in flight");

  // Starting a division makes the divider busy.
  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.op == ivkf_pkg::OP_DSTART && !sts.n_zero |=> !sts.div_idle)
    else $error("divider did not start");

endmodule
`default_nettype wire

/* rtl/ivkf_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ivkf_div
// Restoring divider, one quotient bit per cycle, 32 quotient bits.
// ----------------------------------------------------------------------------
module ivkf_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [33:0] divisor_i,
  output logic        idle_o,
  output logic [31:0] quot_o
);

  logic        busy_q;
  logic [4:0]  cnt_q;
  logic [33:0] rem_q, rem_d;
  logic [31:0] low_q;
  logic [33:0] den_q;
  logic [33:0] trial;
  logic        qbit;

  // The caller guarantees the quotient fits in 32 bits, so the upper half
  // of the dividend is already below the divisor.
  always_comb begin
    trial = {rem_q[32:0], low_q[31]};
    qbit  = (trial >= den_q);
    rem_d = qbit ? trial - den_q : trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 5'd31;
    end else if (busy_q) begin
      if (cnt_q == 5'd0) begin
        busy_q <= 1'b0;
      end
      cnt_q <= cnt_q - 5'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= {2'b0, dividend_i[63:32]};
      low_q <= dividend_i[31:0];
      den_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      low_q <= {low_q[30:0], qbit};
    end
  end

  assign idle_o = !busy_q;
  assign quot_o = low_q;

endmodule
`default_nettype wire

/* rtl/ivkf_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ivkf_ctrl
// Sequencer that steps the datapath through one filter update per item.
// ----------------------------------------------------------------------------
module ivkf_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  ivkf_pkg::sts_t sts_i,
  output ivkf_pkg::cmd_t cmd_o,
  output logic          in_stall_o
);

  ivkf_pkg::op_e state_q, state_d;
  logic [3:0] idx_q, idx_d;
  logic [1:0] col_q, col_d;
  logic [1:0] row_q, row_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ivkf_pkg::OP_IDLE;
      idx_q   <= '0;
      col_q   <= '0;
      row_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      col_q   <= col_d;
      row_q   <= row_d;
    end
  end

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    col_d   = col_q;
    row_d   = row_q;
    cmd_o.op  = state_q;
    cmd_o.idx = idx_q;
    cmd_o.col = col_q;
    cmd_o.row = row_q;
    unique case (state_q)
      ivkf_pkg::OP_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = ivkf_pkg::OP_LOAD;
          state_d  = ivkf_pkg::OP_QMUL;
          idx_d    = '0;
        end
      end
      ivkf_pkg::OP_LOAD: state_d = ivkf_pkg::OP_QMUL;
      ivkf_pkg::OP_QMUL: state_d = ivkf_pkg::OP_QSAVE;
      ivkf_pkg::OP_QSAVE: begin
        if (idx_q == ivkf_pkg::LastProd) begin
          state_d = ivkf_pkg::OP_NORM;
        end else begin
          idx_d   = idx_q + 4'd1;
          state_d = ivkf_pkg::OP_QMUL;
        end
      end
      ivkf_pkg::OP_NORM: begin
        idx_d   = '0;
        state_d = ivkf_pkg::OP_DSTART;
      end
      ivkf_pkg::OP_DSTART: begin
        state_d = sts_i.n_zero ? ivkf_pkg::OP_DSAVE : ivkf_pkg::OP_DWAIT;
      end
      ivkf_pkg::OP_DWAIT: begin
        if (sts_i.div_idle) begin
          state_d = ivkf_pkg::OP_DSAVE;
        end
      end
      ivkf_pkg::OP_DSAVE: begin
        if (idx_q == ivkf_pkg::LastRot) begin
          idx_d   = '0;
          col_d   = '0;
          row_d   = '0;
          state_d = ivkf_pkg::OP_RMUL;
        end else begin
          idx_d   = idx_q + 4'd1;
          state_d = ivkf_pkg::OP_DSTART;
        end
      end
      ivkf_pkg::OP_RMUL: state_d = ivkf_pkg::OP_RACC;
      ivkf_pkg::OP_RACC: begin
        idx_d = idx_q + 4'd1;
        if (col_q == 2'd2) begin
          col_d   = '0;
          state_d = ivkf_pkg::OP_WSAVE;
        end else begin
          col_d   = col_q + 2'd1;
          state_d = ivkf_pkg::OP_RMUL;
        end
      end
      ivkf_pkg::OP_WSAVE: begin
        if (row_q == 2'd2) begin
          state_d = ivkf_pkg::OP_KSTART;
        end else begin
          row_d   = row_q + 2'd1;
          state_d = ivkf_pkg::OP_RMUL;
        end
      end
      ivkf_pkg::OP_KSTART: begin
        state_d = sts_i.den_zero ? ivkf_pkg::OP_KSAVE : ivkf_pkg::OP_KWAIT;
      end
      ivkf_pkg::OP_KWAIT: begin
        if (sts_i.div_idle) begin
          state_d = ivkf_pkg::OP_KSAVE;
        end
      end
      ivkf_pkg::OP_KSAVE: begin
        row_d   = '0;
        state_d = ivkf_pkg::OP_TMUL;
      end
      ivkf_pkg::OP_TMUL:  state_d = ivkf_pkg::OP_ADT;
      ivkf_pkg::OP_ADT:   state_d = ivkf_pkg::OP_VPRED;
      ivkf_pkg::OP_VPRED: state_d = ivkf_pkg::OP_DIFF;
      ivkf_pkg::OP_DIFF:  state_d = ivkf_pkg::OP_KMUL;
      ivkf_pkg::OP_KMUL:  state_d = ivkf_pkg::OP_CORR;
      ivkf_pkg::OP_CORR:  state_d = ivkf_pkg::OP_VSAVE;
      ivkf_pkg::OP_VSAVE: begin
        if (row_q == 2'd2) begin
          state_d = ivkf_pkg::OP_PMUL;
        end else begin
          row_d   = row_q + 2'd1;
          state_d = ivkf_pkg::OP_TMUL;
        end
      end
      ivkf_pkg::OP_PMUL:  state_d = ivkf_pkg::OP_PSAVE;
      ivkf_pkg::OP_PSAVE: state_d = ivkf_pkg::OP_OUT;
      ivkf_pkg::OP_OUT: begin
        // Hold here until the previous result has left the output register.
        if (sts_i.out_blocked) begin
          cmd_o.op = ivkf_pkg::OP_IDLE;
        end else begin
          state_d = ivkf_pkg::OP_IDLE;
        end
      end
      default: state_d = ivkf_pkg::OP_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != ivkf_pkg::OP_IDLE);

endmodule
`default_nettype wire

/* rtl/ivkf_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ivkf_dp
// Datapath: registers, shared multiplier, divider and the output register.
// ----------------------------------------------------------------------------
module ivkf_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ivkf_pkg::cmd_t     cmd_i,
  output ivkf_pkg::sts_t     sts_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [30:0]        cfg_data_i,
  input  logic signed [15:0] quat_w_i,
  input  logic signed [15:0] quat_x_i,
  input  logic signed [15:0] quat_y_i,
  input  logic signed [15:0] quat_z_i,
  input  logic signed [31:0] body_accel_x_i,
  input  logic signed [31:0] body_accel_y_i,
  input  logic signed [31:0] body_accel_z_i,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output logic signed [31:0] vel_x_o,
  output logic signed [31:0] vel_y_o,
  output logic signed [31:0] vel_z_o
);

  logic [15:0] dt_q;
  logic [30:0] qn_q, rn_q, grav_q;
  logic signed [31:0] vel_q [3];
  logic [31:0] cov_q;
  logic out_valid_q;

  logic signed [15:0] quat_q [4];
  logic signed [31:0] accel_q [3];
  logic signed [31:0] qp_q [10];
  logic [32:0] n_q;
  logic signed [31:0] r_q [9];
  logic m_neg_q;
  ivkf_pkg::wide_t prod_q, acc_q;
  logic signed [35:0] world_q [3];
  logic [31:0] p_q;
  logic [16:0] k_q, kc_q;
  logic signed [35:0] adt_q, diff_q, corr_q;
  logic signed [31:0] vp_q;
  logic signed [31:0] vx_q, vy_q, vz_q;

  logic signed [35:0] mul_a;
  logic signed [32:0] mul_b;
  ivkf_pkg::wide_t pa, pb, prod_d;
  logic [1:0] qa_sel, qb_sel;
  logic signed [34:0] ww, xx, yy, zz, xy, wz, xz, wy, yz, wx, m_sel, m_mag;
  logic [32:0] n_d;
  logic [33:0] den;
  logic [32:0] p_sum;
  logic        div_start;
  logic [63:0] div_dividend;
  logic [33:0] div_divisor;
  logic        div_idle;
  logic [31:0] div_quot;
  ivkf_pkg::wide_t w_round;
  ivkf_pkg::wide_t prod_r16;
  logic [16:0] k_d;
  logic        is_diag;

  // Quaternion products are taken in the order ww xx yy zz xy wz xz wy yz wx.
  always_comb begin
    unique case (cmd_i.idx)
      4'd0:    begin qa_sel = 2'd0; qb_sel = 2'd0; end
      4'd1:    begin qa_sel = 2'd1; qb_sel = 2'd1; end
      4'd2:    begin qa_sel = 2'd2; qb_sel = 2'd2; end
      4'd3:    begin qa_sel = 2'd3; qb_sel = 2'd3; end
      4'd4:    begin qa_sel = 2'd1; qb_sel = 2'd2; end
      4'd5:    begin qa_sel = 2'd0; qb_sel = 2'd3; end
      4'd6:    begin qa_sel = 2'd1; qb_sel = 2'd3; end
      4'd7:    begin qa_sel = 2'd0; qb_sel = 2'd2; end
      4'd8:    begin qa_sel = 2'd2; qb_sel = 2'd3; end
      4'd9:    begin qa_sel = 2'd0; qb_sel = 2'd1; end
      default: begin qa_sel = 2'd0; qb_sel = 2'd0; end
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      ivkf_pkg::OP_QMUL: begin
        mul_a = 36'(quat_q[qa_sel]);
        mul_b = 33'(quat_q[qb_sel]);
      end
      ivkf_pkg::OP_RMUL: begin
        mul_a = 36'(r_q[cmd_i.idx]);
        mul_b = 33'(accel_q[cmd_i.col]);
      end
      ivkf_pkg::OP_TMUL: begin
        mul_a = world_q[cmd_i.row];
        mul_b = $signed({17'b0, dt_q});
      end
      ivkf_pkg::OP_KMUL: begin
        mul_a = diff_q;
        mul_b = $signed({16'b0, k_q});
      end
      ivkf_pkg::OP_PMUL: begin
        mul_a = $signed({19'b0, kc_q});
        mul_b = $signed({1'b0, p_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    pa = ivkf_pkg::wide_t'(mul_a);
    pb = ivkf_pkg::wide_t'(mul_b);
    prod_d = pa * pb;
  end

  // Unnormalized rotation numerators and the squared norm.
  always_comb begin
    ww = 35'(qp_q[0]);
    xx = 35'(qp_q[1]);
    yy = 35'(qp_q[2]);
    zz = 35'(qp_q[3]);
    xy = 35'(qp_q[4]);
    wz = 35'(qp_q[5]);
    xz = 35'(qp_q[6]);
    wy = 35'(qp_q[7]);
    yz = 35'(qp_q[8]);
    wx = 35'(qp_q[9]);
    unique case (cmd_i.idx)
      4'd0:    m_sel = ww + xx - yy - zz;
      4'd1:    m_sel = (xy - wz) <<< 1;
      4'd2:    m_sel = (xz + wy) <<< 1;
      4'd3:    m_sel = (xy + wz) <<< 1;
      4'd4:    m_sel = ww - xx + yy - zz;
      4'd5:    m_sel = (yz - wx) <<< 1;
      4'd6:    m_sel = (xz - wy) <<< 1;
      4'd7:    m_sel = (yz + wx) <<< 1;
      4'd8:    m_sel = ww - xx - yy + zz;
      default: m_sel = '0;
    endcase
    m_mag = m_sel[34] ? -m_sel : m_sel;
    n_d = 33'(qp_q[0][31:0]) + 33'(qp_q[1][31:0]) + 33'(qp_q[2][31:0])
        + 33'(qp_q[3][31:0]);
    den   = 34'(p_q) + 34'(rn_q);
    p_sum = 33'(cov_q) + 33'(qn_q);
    is_diag = (cmd_i.idx == 4'd0) || (cmd_i.idx == 4'd4) || (cmd_i.idx == 4'd8);
  end

  always_comb begin
    if (cmd_i.op == ivkf_pkg::OP_KSTART) begin
      div_dividend = ({32'b0, p_q} << 16) + 64'(den >> 1);
      div_divisor  = den;
    end else begin
      div_dividend = (64'(m_mag[32:0]) << 30) + 64'(n_q >> 1);
      div_divisor  = 34'(n_q);
    end
    div_start = ((cmd_i.op == ivkf_pkg::OP_DSTART) && !sts_o.n_zero)
             || ((cmd_i.op == ivkf_pkg::OP_KSTART) && !sts_o.den_zero);
    w_round = ivkf_pkg::rnd_shift(acc_q, 30);
    if (cmd_i.row == 2'd2) begin
      w_round = w_round - ivkf_pkg::wide_t'({1'b0, grav_q});
    end
    prod_r16 = ivkf_pkg::rnd_shift(prod_q, 16);
    k_d = sts_o.den_zero ? 17'd0 : div_quot[16:0];
  end

  ivkf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .idle_o     (div_idle),
    .quot_o     (div_quot)
  );

  // Configuration, filter state and output handshake.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_q        <= ivkf_pkg::TimeStepReset;
      qn_q        <= ivkf_pkg::ProcNoiseReset;
      rn_q        <= ivkf_pkg::MeasNoiseReset;
      grav_q      <= ivkf_pkg::GravityReset;
      vel_q[0]    <= '0;
      vel_q[1]    <= '0;
      vel_q[2]    <= '0;
      cov_q       <= ivkf_pkg::CovReset;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (ivkf_pkg::cfg_idx_e'(cfg_idx_i))
          ivkf_pkg::CFG_TIME_STEP:  dt_q   <= cfg_data_i[15:0];
          ivkf_pkg::CFG_PROC_NOISE: qn_q   <= cfg_data_i;
          ivkf_pkg::CFG_MEAS_NOISE: rn_q   <= cfg_data_i;
          ivkf_pkg::CFG_GRAVITY:    grav_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.op == ivkf_pkg::OP_VSAVE) begin
        vel_q[cmd_i.row] <= ivkf_pkg::sat32(ivkf_pkg::wide_t'(vp_q)
                                          + ivkf_pkg::wide_t'(corr_q));
      end
      if (cmd_i.op == ivkf_pkg::OP_PSAVE) begin
        cov_q <= prod_r16[31:0];
      end
      if (cmd_i.op == ivkf_pkg::OP_OUT) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    case (cmd_i.op)
      ivkf_pkg::OP_LOAD: begin
        quat_q[0]  <= quat_w_i;
        quat_q[1]  <= quat_x_i;
        quat_q[2]  <= quat_y_i;
        quat_q[3]  <= quat_z_i;
        accel_q[0] <= body_accel_x_i;
        accel_q[1] <= body_accel_y_i;
        accel_q[2] <= body_accel_z_i;
        p_q        <= p_sum[32] ? 32'hFFFFFFFF : p_sum[31:0];
      end
      ivkf_pkg::OP_QSAVE:  qp_q[cmd_i.idx] <= prod_q[31:0];
      ivkf_pkg::OP_NORM:   n_q <= n_d;
      ivkf_pkg::OP_DSTART: m_neg_q <= m_sel[34];
      ivkf_pkg::OP_DSAVE: begin
        // A zero quaternion leaves the sample unrotated.
        if (sts_o.n_zero) begin
          r_q[cmd_i.idx] <= is_diag ? ivkf_pkg::OneQ30 : 32'sd0;
        end else begin
          r_q[cmd_i.idx] <= m_neg_q ? -$signed(div_quot) : $signed(div_quot);
        end
      end
      ivkf_pkg::OP_RACC: acc_q <= (cmd_i.col == 2'd0) ? prod_q : acc_q + prod_q;
      ivkf_pkg::OP_WSAVE: world_q[cmd_i.row] <= w_round[35:0];
      ivkf_pkg::OP_KSAVE: begin
        k_q  <= k_d;
        kc_q <= ivkf_pkg::OneQ16 - k_d;
      end
      ivkf_pkg::OP_ADT:   adt_q <= prod_r16[35:0];
      ivkf_pkg::OP_VPRED: begin
        vp_q <= ivkf_pkg::sat32(ivkf_pkg::wide_t'(vel_q[cmd_i.row])
                              + ivkf_pkg::wide_t'(adt_q));
      end
      ivkf_pkg::OP_DIFF:  diff_q <= adt_q - 36'(vp_q);
      ivkf_pkg::OP_CORR:  corr_q <= prod_r16[35:0];
      ivkf_pkg::OP_OUT: begin
        vx_q <= vel_q[0];
        vy_q <= vel_q[1];
        vz_q <= vel_q[2];
      end
      default: ;
    endcase
  end

  assign sts_o.n_zero      = (n_q == 33'd0);
  assign sts_o.den_zero    = (den == 34'd0);
  assign sts_o.div_idle    = div_idle;
  assign sts_o.out_blocked = out_valid_q && out_stall_i;

  assign out_valid_o = out_valid_q;
  assign vel_x_o = vx_q;
  assign vel_y_o = vy_q;
  assign vel_z_o = vz_q;

endmodule
`default_nettype wire
